>>> hdl/current_activity_detector_top_macros.svh
// Assertion macros for the current activity detector.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef CURRENT_ACTIVITY_DETECTOR_TOP_MACROS_SVH
`define CURRENT_ACTIVITY_DETECTOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/cad_pkg.sv
// Package for the current activity detector: widths, command and register
// codes, reset values and shared types. Depends on nothing.
`timescale 1ns / 1ps

package cad_pkg;

   localparam int CMD_W      = 3;
   localparam int ADC_W      = 10;
   localparam int TIME_W     = 32;
   localparam int CUR_W      = 16;
   localparam int THR_W      = 15;
   localparam int HOLD_W     = 16;
   localparam int PERIOD_W   = 8;
   localparam int GAIN_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int RING_DEPTH_DEF = 128;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [ADC_W-1:0]  adc_type;
   typedef logic [TIME_W-1:0] time_type;

   localparam cmd_type CMD_SAMPLE  = 3'd0;
   localparam cmd_type CMD_QUERY   = 3'd1;
   localparam cmd_type CMD_CAPTURE = 3'd2;
   localparam cmd_type CMD_CLEAR   = 3'd3;
   localparam cmd_type CMD_EXPIRE  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN      = 2'd3;

   localparam logic [THR_W-1:0]    THRESHOLD_RST = 15'd100;
   localparam logic [HOLD_W-1:0]   HOLD_RST      = 16'd5000;
   localparam logic [PERIOD_W-1:0] PERIOD_RST    = 8'd1;
   localparam logic [GAIN_W-1:0]   GAIN_RST      = 8'd1;

   localparam adc_type ADC_MAX = 10'd1023;

endpackage

>>> hdl/cad_req_if.sv
// Request channel interface of the current activity detector.
// Depends on cad_pkg.
`timescale 1ns / 1ps

interface cad_req_if import cad_pkg::*; ();
   logic     valid;
   logic     ready;
   cmd_type  command;
   adc_type  adc_value;
   time_type time_ms;

   modport source (output valid, command, adc_value, time_ms, input ready);
   modport sink   (input valid, command, adc_value, time_ms, output ready);
endinterface

>>> hdl/cad_rsp_if.sv
// Response channel interface of the current activity detector.
// Depends on cad_pkg.
`timescale 1ns / 1ps

interface cad_rsp_if import cad_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    active;
   logic signed [CUR_W-1:0] current_ma;
   adc_type                 peak_to_peak;
   logic                    sample_stored;

   modport source (output valid, active, current_ma, peak_to_peak, sample_stored,
                   input ready);
   modport sink   (input valid, active, current_ma, peak_to_peak, sample_stored,
                   output ready);
endinterface

>>> hdl/cad_csr_if.sv
// Register write channel interface of the current activity detector.
// Depends on cad_pkg.
`timescale 1ns / 1ps

interface cad_csr_if import cad_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/cad_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Depends on nothing.
`timescale 1ns / 1ps

module cad_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/current_activity_detector_top.sv
// Top level of the current activity detector: sample ring, min/max scan,
// scaling, hold timer and register file. Depends on cad_pkg, the channel
// interfaces, cad_ram and current_activity_detector_top_macros.svh.
//
//  Channel   Direction  Handshake             Carries
//  req_if    in         valid/ready           command, adc_value, time_ms
//  rsp_if    out        valid/ready           active, current_ma, peak_to_peak, sample_stored
//  csr_if    in         valid/ready (ready=1) index, data
//
// Every transaction passes from acceptance through the EXEC, SCAN, SPAN, MUL
// and FIN states to a loaded response; a clear ring command adds a zeroing
// pass (ST_CLR) before the scan. The scan reads one ring entry per cycle from the
// single read port of the sample memory through its min and max comparisons.
// After reset the ring is zeroed, during which no request is accepted;
// register writes are taken at any time.
// A new request is accepted while the previous response still waits; the
// finished transaction then holds until the response register is free.
`timescale 1ns / 1ps
`include "current_activity_detector_top_macros.svh"

module current_activity_detector_top import cad_pkg::*; #(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   cad_req_if.sink    req_if,
   cad_rsp_if.source  rsp_if,
   cad_csr_if.sink    csr_if
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(RING_DEPTH - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(RING_DEPTH);
   localparam logic [AW-1:0] IDX_LAST = AW'(RING_DEPTH - 1);
   localparam int PROD_W = ADC_W + GAIN_W + 2;

   // Sequencer states.
   localparam logic [2:0] ST_INIT = 3'd0;   // zeroing pass after reset
   localparam logic [2:0] ST_IDLE = 3'd1;   // waiting for a request
   localparam logic [2:0] ST_EXEC = 3'd2;   // command side effects
   localparam logic [2:0] ST_CLR  = 3'd3;   // zeroing pass for clear ring
   localparam logic [2:0] ST_SCAN = 3'd4;   // min/max walk over the ring
   localparam logic [2:0] ST_SPAN = 3'd5;   // peak-to-peak and offset capture
   localparam logic [2:0] ST_MUL  = 3'd6;   // offset correction and gain
   localparam logic [2:0] ST_FIN  = 3'd7;   // saturation, hold timer, response

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   cmd_type     cmd_ff, cmd_in;
   adc_type     adc_ff, adc_in;
   time_type    now_ff, now_in;
   logic [AW-1:0] widx_ff, widx_in;
   time_type    last_sample_ff, last_sample_in;
   time_type    last_above_ff, last_above_in;
   adc_type     offset_ff, offset_in;
   adc_type     lo_ff, lo_in;
   adc_type     hi_ff, hi_in;
   adc_type     p2p_ff, p2p_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic        stored_ff, stored_in;

   logic [THR_W-1:0]    thr_ff;
   logic [HOLD_W-1:0]   hold_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [GAIN_W-1:0]   gain_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_active_ff, rsp_active_in;
   logic signed [CUR_W-1:0] rsp_cur_ff, rsp_cur_in;
   adc_type                 rsp_p2p_ff, rsp_p2p_in;
   logic                    rsp_stored_ff, rsp_stored_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   adc_type       ram_wdata;
   logic [AW-1:0] ram_raddr;
   adc_type       ram_rdata;

   logic signed [ADC_W:0]   diff;
   logic signed [CUR_W-1:0] cur_sat;
   logic signed [CUR_W-1:0] thr_signed;
   logic                    req_fire;

   cad_ram #(
      .WIDTH (ADC_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Register file. Writes are accepted every cycle.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RST;
         hold_ff   <= HOLD_RST;
         period_ff <= PERIOD_RST;
         gain_ff   <= GAIN_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_THRESHOLD: thr_ff    <= csr_if.data[THR_W-1:0];
            REG_HOLD:      hold_ff   <= csr_if.data[HOLD_W-1:0];
            REG_PERIOD:    period_ff <= csr_if.data[PERIOD_W-1:0];
            REG_GAIN:      gain_ff   <= csr_if.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;

   // Offset-corrected span and its saturation to the signed 16-bit range.
   assign diff = $signed({1'b0, p2p_ff}) - $signed({1'b0, offset_ff});
   assign thr_signed = $signed({1'b0, thr_ff});

   always_comb begin
      if (prod_ff > $signed(PROD_W'(32767))) begin
         cur_sat = 16'sh7FFF;
      end else if (prod_ff < -$signed(PROD_W'(32768))) begin
         cur_sat = 16'sh8000;
      end else begin
         cur_sat = prod_ff[CUR_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd_in         = cmd_ff;
      adc_in         = adc_ff;
      now_in         = now_ff;
      widx_in        = widx_ff;
      last_sample_in = last_sample_ff;
      last_above_in  = last_above_ff;
      offset_in      = offset_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      p2p_in         = p2p_ff;
      prod_in        = prod_ff;
      stored_in      = stored_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_active_in  = rsp_active_ff;
      rsp_cur_in     = rsp_cur_ff;
      rsp_p2p_in     = rsp_p2p_ff;
      rsp_stored_in  = rsp_stored_ff;
      ram_we         = 1'b0;
      ram_waddr      = cnt_ff[AW-1:0];
      ram_wdata      = '0;
      ram_raddr      = cnt_ff[AW-1:0];

      case (state_ff)
         ST_INIT, ST_CLR: begin
            ram_we = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_if.command;
               adc_in   = req_if.adc_value;
               now_in   = req_if.time_ms;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            stored_in = 1'b0;
            lo_in     = ADC_MAX;
            hi_in     = '0;
            cnt_in    = '0;
            state_in  = ST_SCAN;
            case (cmd_ff)
               CMD_SAMPLE: begin
                  if ((now_ff - last_sample_ff) > TIME_W'(period_ff)) begin
                     ram_we         = 1'b1;
                     ram_waddr      = widx_ff;
                     ram_wdata      = adc_ff;
                     widx_in        = (widx_ff == IDX_LAST) ? '0 : widx_ff + 1'b1;
                     last_sample_in = now_ff;
                     stored_in      = 1'b1;
                  end
               end
               CMD_CLEAR: begin
                  state_in = ST_CLR;
               end
               CMD_EXPIRE: begin
                  last_above_in = now_ff - TIME_W'(hold_ff) - 1'b1;
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            // Read data arrives in the cycle after its address.
            if (cnt_ff != '0) begin
               if (ram_rdata < lo_ff) begin
                  lo_in = ram_rdata;
               end
               if (ram_rdata > hi_ff) begin
                  hi_in = ram_rdata;
               end
            end
            if (cnt_ff == CNT_END) begin
               state_in = ST_SPAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SPAN: begin
            p2p_in = hi_ff - lo_ff;
            if (cmd_ff == CMD_CAPTURE) begin
               offset_in = hi_ff - lo_ff;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Both factors are sign-extended to the product width first.
            prod_in  = $signed(PROD_W'(diff)) * $signed(PROD_W'({1'b0, gain_ff}));
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Wait here until the response register is free.
            if (!rsp_valid_in) begin
               rsp_active_in = 1'b1;
               if (cmd_ff == CMD_QUERY) begin
                  if (cur_sat > thr_signed) begin
                     last_above_in = now_ff;
                  end else if (cur_sat < thr_signed &&
                               (now_ff - last_above_ff) > TIME_W'(hold_ff)) begin
                     rsp_active_in = 1'b0;
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_cur_in    = cur_sat;
               rsp_p2p_in    = p2p_ff;
               rsp_stored_in = stored_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         cnt_ff         <= '0;
         widx_ff        <= '0;
         last_sample_ff <= '0;
         last_above_ff  <= '0;
         offset_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         widx_ff        <= widx_in;
         last_sample_ff <= last_sample_in;
         last_above_ff  <= last_above_in;
         offset_ff      <= offset_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      adc_ff        <= adc_in;
      now_ff        <= now_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      p2p_ff        <= p2p_in;
      prod_ff       <= prod_in;
      stored_ff     <= stored_in;
      rsp_active_ff <= rsp_active_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_p2p_ff    <= rsp_p2p_in;
      rsp_stored_ff <= rsp_stored_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.active        = rsp_active_ff;
   assign rsp_if.current_ma    = rsp_cur_ff;
   assign rsp_if.peak_to_peak  = rsp_p2p_ff;
   assign rsp_if.sample_stored = rsp_stored_ff;

   // An accepted request keeps the block busy for the following cycle.
   `CAD_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_if.ready, "request accepted back to back")
   // A response that reports a stored sample never reports inactivity.
   `CAD_ASSERT_NOW(a_store_act, rsp_valid_ff && rsp_stored_ff, rsp_active_ff, "inactive store")
   // The ring write pointer stays inside the ring.
   `CAD_ASSERT_NOW(a_widx_range, 1'b1, {1'b0, widx_ff} < CNT_END, "write index beyond ring")
   // No request is taken during the zeroing pass after reset.
   `CAD_ASSERT_NOW(a_init_busy, state_ff == ST_INIT, !req_if.ready, "request taken during zeroing")

endmodule
